// ===== hdl/tbo_pkg.sv =====
// tbo_pkg: shared types and constants for the triangle/box overlap test
// no dependencies

package tbo_pkg;

  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X  = 3'd0,
    CFG_MIN_Y  = 3'd1,
    CFG_MIN_Z  = 3'd2,
    CFG_SIZE_X = 3'd3,
    CFG_SIZE_Y = 3'd4,
    CFG_SIZE_Z = 3'd5
  } cfg_idx_t;

  localparam int NUM_STAGES = 6;

endpackage

// ===== hdl/triangle_box_overlap_test.sv =====
// triangle_box_overlap_test: separating-axis triangle versus box test, six stage pipeline
// depends on tbo_pkg
//
//  channel  handshake            payload
//  in       in_valid / in_stall  in_vertex0_x .. in_vertex2_z
//  out      out_valid/ out_stall out_overlaps
//  cfg      cfg_we               cfg_idx, cfg_wdata
//
// one triangle per cycle while the output is not stalled, out_valid rises when the request reaches the output register
// stage 3 holds the edge-axis and normal multipliers, stages 4..5 the split
// plane-test multiply, stage 6 the final sums and the output register
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// synchronous reset clears valid bits and restores the unit box at the origin

module triangle_box_overlap_test #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tbo_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [COORD_BITS-1:0]           cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    in_vertex0_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex0_y,
  input  logic signed [COORD_BITS-1:0]    in_vertex0_z,
  input  logic signed [COORD_BITS-1:0]    in_vertex1_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex1_y,
  input  logic signed [COORD_BITS-1:0]    in_vertex1_z,
  input  logic signed [COORD_BITS-1:0]    in_vertex2_x,
  input  logic signed [COORD_BITS-1:0]    in_vertex2_y,
  input  logic signed [COORD_BITS-1:0]    in_vertex2_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_overlaps
);
  import tbo_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int V_W  = C + 3;
  localparam int E_W  = C + 4;
  localparam int P_W  = 2 * C + 9;
  localparam int N_W  = 2 * C + 9;
  localparam int NV_W = C + 4;
  localparam int K    = C + 4;
  localparam int HI_W = N_W - K;
  localparam int PL_W = K + 1 + NV_W;
  localparam int PH_W = HI_W + NV_W;
  localparam int D_W  = 3 * C + 15;

  // configuration
  logic signed [C-1:0] mn_r [3];
  logic        [C-2:0] sz_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        mn_r[k] <= '0;
        sz_r[k] <= (C-1)'(1) << FRAC_BITS;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MIN_X:  mn_r[0] <= cfg_wdata;
        CFG_MIN_Y:  mn_r[1] <= cfg_wdata;
        CFG_MIN_Z:  mn_r[2] <= cfg_wdata;
        CFG_SIZE_X: sz_r[0] <= cfg_wdata[C-2:0];
        CFG_SIZE_Y: sz_r[1] <= cfg_wdata[C-2:0];
        CFG_SIZE_Z: sz_r[2] <= cfg_wdata[C-2:0];
        default: ;
      endcase
    end
  end

  // half size in doubled units, as signed
  logic signed [C-1:0] h [3];
  always_comb begin
    for (int k = 0; k < 3; k++) h[k] = $signed({1'b0, sz_r[k]});
  end

  // pipeline control
  logic [NUM_STAGES-1:0] vld_r;
  logic en;
  assign en        = !(vld_r[NUM_STAGES-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // stage 1: vertices relative to the box center, doubled
  logic signed [C-1:0]   vin [3][3];
  logic signed [V_W-1:0] v1_nxt [3][3];
  logic signed [V_W-1:0] v1_r   [3][3];

  always_comb begin
    vin[0][0] = in_vertex0_x; vin[0][1] = in_vertex0_y; vin[0][2] = in_vertex0_z;
    vin[1][0] = in_vertex1_x; vin[1][1] = in_vertex1_y; vin[1][2] = in_vertex1_z;
    vin[2][0] = in_vertex2_x; vin[2][1] = in_vertex2_y; vin[2][2] = in_vertex2_z;
    for (int q = 0; q < 3; q++) begin
      for (int k = 0; k < 3; k++) begin
        v1_nxt[q][k] = (V_W'(vin[q][k]) <<< 1) - (V_W'(mn_r[k]) <<< 1) - V_W'(h[k]);
      end
    end
  end

  // stage 2: edges and the box-axis tests
  logic signed [E_W-1:0] e2_nxt [3][3];
  logic signed [E_W-1:0] e2_r   [3][3];
  logic signed [V_W-1:0] v2_r   [3][3];
  logic                  sbox2_nxt, sbox2_r;

  always_comb begin
    logic signed [V_W-1:0] lo, hi;
    sbox2_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      e2_nxt[0][k] = E_W'(v1_r[1][k]) - E_W'(v1_r[0][k]);
      e2_nxt[1][k] = E_W'(v1_r[2][k]) - E_W'(v1_r[1][k]);
      e2_nxt[2][k] = E_W'(v1_r[0][k]) - E_W'(v1_r[2][k]);
    end
    for (int k = 0; k < 3; k++) begin
      lo = v1_r[0][k];
      hi = v1_r[0][k];
      for (int q = 1; q < 3; q++) begin
        if (v1_r[q][k] < lo) lo = v1_r[q][k];
        if (v1_r[q][k] > hi) hi = v1_r[q][k];
      end
      if (lo > V_W'(h[k]) || hi < -V_W'(h[k])) sbox2_nxt = 1'b1;
    end
  end

  // stage 3: edge-axis projections, radii and the triangle normal
  logic signed [P_W-1:0] p3_nxt [9][3];
  logic signed [P_W-1:0] p3_r   [9][3];
  logic signed [P_W-1:0] r3_nxt [9];
  logic signed [P_W-1:0] r3_r   [9];
  logic signed [N_W-1:0] n3_nxt [3];
  logic signed [N_W-1:0] n3_r   [3];
  logic signed [V_W-1:0] v03_r  [3];
  logic                  sbox3_r;

  always_comb begin
    int i, j;
    logic signed [E_W-1:0] ai, aj;
    for (int q = 0; q < 3; q++) begin
      for (int k = 0; k < 3; k++) begin
        i  = (k + 1) % 3;
        j  = (k + 2) % 3;
        ai = e2_r[q][i] < 0 ? -e2_r[q][i] : e2_r[q][i];
        aj = e2_r[q][j] < 0 ? -e2_r[q][j] : e2_r[q][j];
        for (int t = 0; t < 3; t++) begin
          p3_nxt[q*3+k][t] = P_W'(e2_r[q][j]) * P_W'(v2_r[t][i])
                           - P_W'(e2_r[q][i]) * P_W'(v2_r[t][j]);
        end
        r3_nxt[q*3+k] = P_W'(aj) * P_W'(h[i]) + P_W'(ai) * P_W'(h[j]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      n3_nxt[k] = N_W'(e2_r[0][i]) * N_W'(e2_r[1][j]) - N_W'(e2_r[0][j]) * N_W'(e2_r[1][i]);
    end
  end

  // stage 4: edge separation, plane-test partial products
  logic                  sedge4_nxt, sedge4_r, sbox4_r;
  logic signed [PL_W-1:0] pl4_nxt [2][3];
  logic signed [PL_W-1:0] pl4_r   [2][3];
  logic signed [PH_W-1:0] ph4_nxt [2][3];
  logic signed [PH_W-1:0] ph4_r   [2][3];

  always_comb begin
    logic signed [P_W-1:0]  pmn, pmx;
    logic signed [NV_W-1:0] nv [2];
    logic signed [K:0]      nlo;
    logic signed [HI_W-1:0] nhi;
    sedge4_nxt = 1'b0;
    for (int a = 0; a < 9; a++) begin
      pmn = p3_r[a][0];
      pmx = p3_r[a][0];
      for (int t = 1; t < 3; t++) begin
        if (p3_r[a][t] < pmn) pmn = p3_r[a][t];
        if (p3_r[a][t] > pmx) pmx = p3_r[a][t];
      end
      if (r3_r[a] < pmn || pmx < -r3_r[a]) sedge4_nxt = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      // nearest and farthest box corner along the normal
      if (n3_r[k] > 0) begin
        nv[0] = -NV_W'(h[k]) - NV_W'(v03_r[k]);
        nv[1] =  NV_W'(h[k]) - NV_W'(v03_r[k]);
      end else begin
        nv[0] =  NV_W'(h[k]) - NV_W'(v03_r[k]);
        nv[1] = -NV_W'(h[k]) - NV_W'(v03_r[k]);
      end
      nlo = $signed({1'b0, n3_r[k][K-1:0]});
      nhi = n3_r[k][N_W-1:K];
      for (int m = 0; m < 2; m++) begin
        pl4_nxt[m][k] = PL_W'(nlo) * PL_W'(nv[m]);
        ph4_nxt[m][k] = PH_W'(nhi) * PH_W'(nv[m]);
      end
    end
  end

  // stage 5: recombine the split products
  logic signed [D_W-1:0] d5_nxt [2][3];
  logic signed [D_W-1:0] d5_r   [2][3];
  logic                  sep5_r;

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      for (int k = 0; k < 3; k++) begin
        d5_nxt[m][k] = (D_W'(ph4_r[m][k]) <<< K) + D_W'(pl4_r[m][k]);
      end
    end
  end

  // stage 6: plane test and result
  logic overlaps_nxt, overlaps_r;
  always_comb begin
    logic signed [D_W-1:0] dmin, dmax;
    dmin = d5_r[0][0] + d5_r[0][1] + d5_r[0][2];
    dmax = d5_r[1][0] + d5_r[1][1] + d5_r[1][2];
    overlaps_nxt = !(sep5_r || dmin > 0 || dmax < 0);
  end
  assign out_overlaps = overlaps_r;

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r      <= v1_nxt;
      e2_r      <= e2_nxt;
      v2_r      <= v1_r;
      sbox2_r   <= sbox2_nxt;
      p3_r      <= p3_nxt;
      r3_r      <= r3_nxt;
      n3_r      <= n3_nxt;
      v03_r     <= v2_r[0];
      sbox3_r   <= sbox2_r;
      sedge4_r  <= sedge4_nxt;
      sbox4_r   <= sbox3_r;
      pl4_r     <= pl4_nxt;
      ph4_r     <= ph4_nxt;
      d5_r      <= d5_nxt;
      sep5_r    <= sedge4_r || sbox4_r;
      overlaps_r <= overlaps_nxt;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for triangle_box_overlap_test (triangle vs box SAT test)
// depends on tbo_pkg and the DUT; directed triangles, then random ones over several boxes

`timescale 1ns / 1ps

module tb_top;
  import tbo_pkg::*;

  localparam int CB = 24;

  typedef struct {
    logic signed [CB-1:0] c [9];
  } tri_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CB-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] vin [9] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_overlaps;

  always #5 clk = ~clk;

  triangle_box_overlap_test DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex0_x(vin[0]), .in_vertex0_y(vin[1]), .in_vertex0_z(vin[2]),
    .in_vertex1_x(vin[3]), .in_vertex1_y(vin[4]), .in_vertex1_z(vin[5]),
    .in_vertex2_x(vin[6]), .in_vertex2_y(vin[7]), .in_vertex2_z(vin[8]),
    .out_valid(out_valid), .out_stall(out_stall), .out_overlaps(out_overlaps)
  );

  // predictor copy of the box
  logic signed [CB-1:0] box_lo [3];
  logic [CB-2:0] box_ext [3];

  tri_t pending_tris [$];
  bit overlap_expect [$];
  int errors = 0;
  int n_checked = 0;
  int n_hits = 0;
  bit hold_off = 1'b0;

  function automatic logic signed [127:0] wabs(logic signed [127:0] a);
    return a < 0 ? -a : a;
  endfunction

  function automatic bit predict_overlap(tri_t t);
    logic signed [127:0] v [3][3];
    logic signed [127:0] e [3][3];
    logic signed [127:0] h [3];
    logic signed [127:0] n [3];
    logic signed [127:0] p, mn, mx, rad, lo, hi, dmin, dmax, vmn, vmx;
    int i, j;
    bit sep;
    sep = 0;
    for (int k = 0; k < 3; k++) h[k] = {105'd0, box_ext[k]};
    for (int q = 0; q < 3; q++)
      for (int k = 0; k < 3; k++)
        v[q][k] = 2 * 128'(t.c[q*3+k]) - 2 * 128'(box_lo[k]) - h[k];
    for (int k = 0; k < 3; k++) begin
      e[0][k] = v[1][k] - v[0][k];
      e[1][k] = v[2][k] - v[1][k];
      e[2][k] = v[0][k] - v[2][k];
    end
    for (int q = 0; q < 3; q++)
      for (int k = 0; k < 3; k++) begin
        i = (k + 1) % 3;
        j = (k + 2) % 3;
        for (int r = 0; r < 3; r++) begin
          p = e[q][j] * v[r][i] - e[q][i] * v[r][j];
          if (r == 0) begin
            mn = p;
            mx = p;
          end else begin
            if (p < mn) mn = p;
            if (p > mx) mx = p;
          end
        end
        rad = wabs(e[q][j]) * h[i] + wabs(e[q][i]) * h[j];
        if (mn > rad || mx < -rad) sep = 1;
      end
    for (int k = 0; k < 3; k++) begin
      lo = v[0][k];
      hi = v[0][k];
      for (int q = 1; q < 3; q++) begin
        if (v[q][k] < lo) lo = v[q][k];
        if (v[q][k] > hi) hi = v[q][k];
      end
      if (lo > h[k] || hi < -h[k]) sep = 1;
    end
    dmin = 0;
    dmax = 0;
    for (int k = 0; k < 3; k++) begin
      i = (k + 1) % 3;
      j = (k + 2) % 3;
      n[k] = e[0][i] * e[1][j] - e[0][j] * e[1][i];
      if (n[k] > 0) begin
        vmn = -h[k] - v[0][k];
        vmx = h[k] - v[0][k];
      end else begin
        vmn = h[k] - v[0][k];
        vmx = -h[k] - v[0][k];
      end
      dmin = dmin + n[k] * vmn;
      dmax = dmax + n[k] * vmx;
    end
    if (dmin > 0 || dmax < 0) sep = 1;
    return !sep;
  endfunction

  // driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        bit ov;
        ov = predict_overlap(pending_tris.pop_front());
        overlap_expect = {overlap_expect, ov};
        burst_left = burst_left - 1;
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_tris.size() > 0) begin
        if (burst_left <= 0 && in_valid && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 6);
          burst_left = $urandom_range(1, 30);
        end else begin
          in_valid <= 1'b1;
          for (int k = 0; k < 9; k++) vin[k] <= pending_tris[0].c[k];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_off) out_stall <= 1'b1;
    else if (stall_phase % 400 < 100) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // long hold-off once, counted here
  initial begin
    wait (rst_n);
    repeat (500) @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (overlap_expect.size() == 0) begin
        $error("overlaps: result with no request pending, actual %0d", out_overlaps);
        errors++;
      end else begin
        bit exp_ov;
        exp_ov = overlap_expect.pop_front();
        n_checked++;
        if (exp_ov) n_hits++;
        if (out_overlaps !== exp_ov) begin
          $error("overlaps mismatch: expected %0d actual %0d", exp_ov, out_overlaps);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CB-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    box_lo[0] = (idx == CFG_MIN_X) ? val : box_lo[0];
    box_lo[1] = (idx == CFG_MIN_Y) ? val : box_lo[1];
    box_lo[2] = (idx == CFG_MIN_Z) ? val : box_lo[2];
    if (idx == CFG_SIZE_X) box_ext[0] = val[CB-2:0];
    if (idx == CFG_SIZE_Y) box_ext[1] = val[CB-2:0];
    if (idx == CFG_SIZE_Z) box_ext[2] = val[CB-2:0];
  endtask

  task automatic set_box(logic [CB-1:0] lx, logic [CB-1:0] ly, logic [CB-1:0] lz,
                         logic [CB-1:0] sx, logic [CB-1:0] sy, logic [CB-1:0] sz);
    write_reg(CFG_MIN_X, lx);
    write_reg(CFG_MIN_Y, ly);
    write_reg(CFG_MIN_Z, lz);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
  endtask

  task automatic drain();
    wait (pending_tris.size() == 0 && !in_valid && overlap_expect.size() == 0);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] near_box(int k, int spread);
    return CB'(box_lo[k] + box_ext[k] / 2 + $signed(CB'($urandom_range(0, 2 * spread)))
               - spread);
  endfunction

  task automatic add_tri(logic [CB-1:0] a [9]);
    tri_t t;
    for (int k = 0; k < 9; k++) t.c[k] = a[k];
    pending_tris = {pending_tris, t};
  endtask

  task automatic add_random(int count, int spread);
    logic [CB-1:0] a [9];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0)
        for (int k = 0; k < 9; k++) a[k] = CB'($urandom);
      else
        for (int k = 0; k < 9; k++) a[k] = near_box(k % 3, spread);
      if ($urandom_range(0, 15) == 0) begin
        // collinear or repeated vertex: zero normal
        for (int k = 0; k < 3; k++) a[6+k] = a[3+k];
      end
      add_tri(a);
    end
  endtask

  initial begin
    logic [CB-1:0] a [9];
    box_lo = '{default: '0};
    box_ext = '{default: 23'(65536)};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default unit box
    a = '{default: 24'sd0};
    add_tri(a);                                   // point at corner, touching
    a = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
          24'h7FFFFF, 24'h800000, 24'h7FFFFF};
    add_tri(a);
    a = '{default: 24'h800000};
    add_tri(a);
    a = '{default: 24'h7FFFFF};
    add_tri(a);
    a = '{24'd65536, 24'd0, 24'd0, 24'd0, 24'd65536, 24'd0, 24'd0, 24'd0, 24'd65536};
    add_tri(a);
    a = '{24'd131072, 24'd0, 24'd0, 24'd0, 24'd131072, 24'd0, 24'd0, 24'd0, 24'd131072};
    add_tri(a);                                   // edges touch three box corners
    a = '{24'd131073, 24'd0, 24'd0, 24'd0, 24'd131073, 24'd0, 24'd0, 24'd0, 24'd131073};
    add_tri(a);                                   // edges just past those corners
    a = '{24'd65537, 24'd0, 24'd0, 24'd65537, 24'd65536, 24'd0, 24'd65537, 24'd0, 24'd65536};
    add_tri(a);                                   // beside x face
    a = '{24'd65536, 24'd0, 24'd0, 24'd65536, 24'd65536, 24'd0, 24'd65536, 24'd0, 24'd65536};
    add_tri(a);                                   // lying on x face
    a = '{-24'sd10, 24'd5, 24'd5, 24'd200000, 24'd5, 24'd5, 24'd50, 24'd5, 24'd5};
    add_tri(a);                                   // degenerate through the box
    add_random(10, 200000);
    drain();

    // zero-size box, max box, random boxes
    set_box(24'd1000, -24'sd1000, 24'd0, 24'd0, 24'd0, 24'd0);
    a = '{24'd1000, -24'sd1000, 24'd0, 24'd5000, -24'sd1000, 24'd0, 24'd1000, 24'd9, 24'd0};
    add_tri(a);
    add_random(60, 3000);
    drain();
    set_box(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    add_random(80, 8388607);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_box(CB'($urandom), CB'($urandom_range(0, 1 << 20) - (1 << 19)),
              CB'($urandom_range(0, 40000)),
              CB'($urandom_range(0, 8388607)), CB'($urandom_range(0, 300000)),
              CB'($urandom_range(0, 100000)));
      add_random(185, 400000);
      drain();
    end

    $display("checked %0d triangles over 9 box settings, %0d overlapping", n_checked, n_hits);
    if (errors == 0 && overlap_expect.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
